// ===== rtl/pfn_pkg.sv =====
// ----------------------------------------------------------------------------
// pfn_pkg: shared definitions for the Perlin fBm noise unit
// Constants, register indexes, command codes, state and interface types.
// ----------------------------------------------------------------------------
package pfn_pkg;

	localparam int MAX_OCTAVES = 16;
	localparam int TABLE_SIZE  = 256;
	localparam int TBL_AW      = $clog2(TABLE_SIZE);
	localparam int FRAC_BITS   = 16;
	localparam int PERM_PORTS  = 6;

	// Fade polynomial constants in Q.16.
	localparam logic [19:0] FADE_C15 = 20'(15 * (1 << FRAC_BITS));
	localparam logic [19:0] FADE_C10 = 20'(10 * (1 << FRAC_BITS));
	localparam logic signed [18:0] ONE_FX = 19'sd65536;

	// Register reset values.
	localparam logic [4:0]  OCTAVES_RESET   = 5'd10;
	localparam logic [23:0] BASE_FREQ_RESET = 24'd83886;

	// Configuration register indexes.
	localparam logic [1:0] REG_OCTAVES   = 2'd0;
	localparam logic [1:0] REG_BASE_FREQ = 2'd1;

	// Input command codes.
	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_PERM = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} pfn_state_t;

	// Permutation table write.
	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [7:0]        data;
	} perm_wr_t;

	// One octave issued into the evaluator.
	typedef struct packed {
		logic        valid;
		logic        last;
		logic [3:0]  shift;
		logic [31:0] px;
		logic [31:0] py;
	} oct_issue_t;

	// One octave contribution leaving the evaluator.
	typedef struct packed {
		logic               valid;
		logic               last;
		logic signed [21:0] value;
	} oct_res_t;

	// Dot product of a (+-1,+-1) gradient with a corner offset.
	function automatic logic signed [18:0] grad_dot(input logic [1:0] g,
			input logic signed [18:0] dx, input logic signed [18:0] dy);
		logic signed [18:0] sx;
		logic signed [18:0] sy;
		sx = (g == 2'd0 || g == 2'd3) ? dx : -dx;
		sy = (g[1] == 1'b0) ? dy : -dy;
		return sx + sy;
	endfunction

endpackage

// ===== rtl/perlin_fbm_noise_2d_unit.sv =====
// Operation: an evaluate word runs n octaves, where n is the octave count limited to sixteen;
// with n zero the sum stays zero. A table write goes straight to the permutation store.
// The unit takes no new word until the last result is loaded into the output register; the
// octave loop issues one octave per cycle into the seven-stage evaluator.
// Reset: asynchronous, active low; registers return to their reset values and
// the permutation table reads as the identity until entries are written.
// ----------------------------------------------------------------------------
// perlin_fbm_noise_2d_unit: 2D Perlin gradient noise with octave summation
// Sequences octaves through the pipelined evaluator, accumulates them and
// maps the sum to a Q2.16 value and a pixel byte.
// ----------------------------------------------------------------------------
module perlin_fbm_noise_2d_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [15:0] x_coord,
	input  logic signed [15:0] y_coord,
	input  logic [7:0]         perm_index,
	input  logic [7:0]         perm_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] noise_value,
	output logic [7:0]         pixel_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	pfn_pkg::pfn_state_t state_q, state_d;
	logic [4:0]  octaves_q;
	logic [23:0] base_q;
	logic [31:0] xb_q, yb_q;
	logic [3:0]  oct_q;
	logic [4:0]  n_q;
	logic signed [25:0] sum_q;

	pfn_pkg::oct_issue_t iss;
	pfn_pkg::oct_res_t   res;
	pfn_pkg::perm_wr_t   pwr;

	logic in_acc, out_load, last_iss;
	logic [4:0] n_eff;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != pfn_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign n_eff     = (octaves_q > 5'(pfn_pkg::MAX_OCTAVES)) ?
		5'(pfn_pkg::MAX_OCTAVES) : octaves_q;
	assign last_iss  = ({1'b0, oct_q} == (n_q - 5'd1));
	assign out_load  = (state_q == pfn_pkg::ST_DONE) && (!out_valid || !out_stall);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= pfn_pkg::OCTAVES_RESET;
			base_q    <= pfn_pkg::BASE_FREQ_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				pfn_pkg::REG_OCTAVES:   octaves_q <= cfg_data[4:0];
				pfn_pkg::REG_BASE_FREQ: base_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table writes go straight to the store while the evaluator is empty.
	assign pwr.en   = in_acc && (cmd == pfn_pkg::CMD_PERM);
	assign pwr.addr = perm_index;
	assign pwr.data = perm_value;

	// Octave issue: the base product shifted by the octave number.
	assign iss.valid = (state_q == pfn_pkg::ST_ISSUE);
	assign iss.last  = last_iss;
	assign iss.shift = oct_q;
	assign iss.px    = xb_q << oct_q;
	assign iss.py    = yb_q << oct_q;

	pfn_octave u_oct (
		.clk   (clk),
		.arst_n(arst_n),
		.iss   (iss),
		.wr    (pwr),
		.res   (res)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfn_pkg::ST_IDLE: begin
				if (in_acc && cmd == pfn_pkg::CMD_EVAL) begin
					state_d = (n_eff == 5'd0) ? pfn_pkg::ST_DONE : pfn_pkg::ST_ISSUE;
				end
			end
			pfn_pkg::ST_ISSUE: begin
				if (last_iss) begin
					state_d = pfn_pkg::ST_DRAIN;
				end
			end
			pfn_pkg::ST_DRAIN: begin
				if (res.valid && res.last) begin
					state_d = pfn_pkg::ST_DONE;
				end
			end
			pfn_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = pfn_pkg::ST_IDLE;
				end
			end
			default: state_d = pfn_pkg::ST_IDLE;
		endcase
	end

	// Coordinate scaling, octave counter and accumulator.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			xb_q  <= 32'(x_coord * $signed({1'b0, base_q}));
			yb_q  <= 32'(y_coord * $signed({1'b0, base_q}));
			n_q   <= n_eff;
			oct_q <= '0;
			sum_q <= '0;
		end else begin
			if (state_q == pfn_pkg::ST_ISSUE) begin
				oct_q <= oct_q + 4'd1;
			end
			if (res.valid) begin
				sum_q <= sum_q + 26'(res.value);
			end
		end
	end

	// Saturation to Q2.16 and the byte mapping.
	logic signed [17:0] q_sat;
	logic signed [19:0] s_val;
	logic [27:0]        b_prod;
	logic [10:0]        b_raw;
	logic [7:0]         byte_d;

	always_comb begin
		if (sum_q > 26'sd131071) begin
			q_sat = 18'sd131071;
		end else if (sum_q < -26'sd131072) begin
			q_sat = -18'sd131072;
		end else begin
			q_sat = sum_q[17:0];
		end
		s_val  = 20'(q_sat) + 20'sd65536;
		b_prod = 28'(s_val) * 28'd255 + 28'd65536;
		b_raw  = b_prod[27:17];
		if (s_val <= 20'sd0) begin
			byte_d = 8'd0;
		end else if (b_raw > 11'd255) begin
			byte_d = 8'd255;
		end else begin
			byte_d = b_raw[7:0];
		end
	end

	// Output register: holds the word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			noise_value <= q_sat;
			pixel_byte  <= byte_d;
		end
	end

`ifndef ASSERT_OFF
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == pfn_pkg::ST_ISSUE || state_q == pfn_pkg::ST_DRAIN))
		else $error("octave result outside an evaluation");
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfn_pkg::ST_DONE) |-> !res.valid)
		else $error("evaluator not empty when the sum is final");
	a_iss_range: assert property (@(posedge clk) disable iff (!arst_n)
		iss.valid |-> ({1'b0, oct_q} < n_q))
		else $error("octave issued beyond the count");
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pwr.en |=> (state_q == pfn_pkg::ST_IDLE))
		else $error("table write started an evaluation");
`endif

endmodule

// ===== rtl/pfn_ram.sv =====
// ----------------------------------------------------------------------------
// pfn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pfn_perm.sv =====
// ----------------------------------------------------------------------------
// pfn_perm: permutation table with six read ports
// Six identical RAM copies share one write; valid bits give the identity
// value for entries never written since reset.
// ----------------------------------------------------------------------------
module pfn_perm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pfn_pkg::perm_wr_t         wr,
	input  logic [pfn_pkg::TBL_AW-1:0] raddr [pfn_pkg::PERM_PORTS],
	output logic [7:0]                rdata [pfn_pkg::PERM_PORTS]
);

	logic [pfn_pkg::TABLE_SIZE-1:0] vld_q;
	logic [pfn_pkg::PERM_PORTS-1:0] rvld_q;
	logic [pfn_pkg::TBL_AW-1:0]     raddr_q [pfn_pkg::PERM_PORTS];
	logic [7:0]                     ram_rd [pfn_pkg::PERM_PORTS];

	// Valid bit per entry, set on its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	for (genvar p = 0; p < pfn_pkg::PERM_PORTS; p++) begin : g_port
		pfn_ram #(
			.WIDTH(8),
			.DEPTH(pfn_pkg::TABLE_SIZE)
		) u_ram (
			.clk  (clk),
			.we   (wr.en),
			.waddr(wr.addr),
			.wdata(wr.data),
			.raddr(raddr[p]),
			.rdata(ram_rd[p])
		);

		// Registered valid and address, aligned with the RAM read.
		always_ff @(posedge clk) begin
			rvld_q[p]  <= vld_q[raddr[p]];
			raddr_q[p] <= raddr[p];
		end

		// An unwritten entry holds its own index.
		assign rdata[p] = rvld_q[p] ? ram_rd[p] : 8'(raddr_q[p]);
	end

endmodule

// ===== rtl/pfn_octave.sv =====
// ----------------------------------------------------------------------------
// pfn_octave: seven-stage pipelined single-octave noise evaluator
// Takes one scaled coordinate pair per cycle and returns the octave's
// gradient noise, already scaled by its amplitude.
// ----------------------------------------------------------------------------
module pfn_octave (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pfn_pkg::oct_issue_t   iss,
	input  pfn_pkg::perm_wr_t     wr,
	output pfn_pkg::oct_res_t     res
);

	localparam int FB = pfn_pkg::FRAC_BITS;

	logic [pfn_pkg::TBL_AW-1:0] raddr [pfn_pkg::PERM_PORTS];
	logic [7:0]                 rdata [pfn_pkg::PERM_PORTS];

	pfn_perm u_perm (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Control travelling with the data.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6, l_s7;
	logic [3:0] sh_s1, sh_s2, sh_s3, sh_s4, sh_s5, sh_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			v_s1 <= iss.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		l_s1 <= iss.last; l_s2 <= l_s1; l_s3 <= l_s2; l_s4 <= l_s3;
		l_s5 <= l_s4; l_s6 <= l_s5; l_s7 <= l_s6;
		sh_s1 <= iss.shift; sh_s2 <= sh_s1; sh_s3 <= sh_s2;
		sh_s4 <= sh_s3; sh_s5 <= sh_s4; sh_s6 <= sh_s5;
	end

	// Stage 1: cell and fraction, first table reads, first fade products.
	logic [7:0]  cx, cy;
	logic [15:0] tx, ty;
	logic [19:0] kx, ky;
	assign cx = iss.px[31:24];
	assign cy = iss.py[31:24];
	assign tx = iss.px[23:24-FB];
	assign ty = iss.py[23:24-FB];
	assign kx = pfn_pkg::FADE_C15 - (20'(tx) * 20'd6);
	assign ky = pfn_pkg::FADE_C15 - (20'(ty) * 20'd6);
	assign raddr[0] = cx;
	assign raddr[1] = cx + 8'd1;

	logic [7:0]  cy_s1;
	logic [15:0] tx_s1, ty_s1;
	logic [35:0] ix_s1, iy_s1;
	logic [31:0] t2x_s1, t2y_s1;

	always_ff @(posedge clk) begin
		cy_s1  <= cy;
		tx_s1  <= tx;
		ty_s1  <= ty;
		ix_s1  <= 36'(tx) * 36'(kx);
		iy_s1  <= 36'(ty) * 36'(ky);
		t2x_s1 <= 32'(tx) * 32'(tx);
		t2y_s1 <= 32'(ty) * 32'(ty);
	end

	// Stage 2: corner hash reads, fade polynomial and cube.
	logic [7:0] pa, pb;
	logic [31:0] t3x_full, t3y_full;
	assign pa = rdata[0];
	assign pb = rdata[1];
	assign raddr[2] = pa + cy_s1;
	assign raddr[3] = pa + cy_s1 + 8'd1;
	assign raddr[4] = pb + cy_s1;
	assign raddr[5] = pb + cy_s1 + 8'd1;
	assign t3x_full = 32'(t2x_s1[31:16]) * 32'(tx_s1);
	assign t3y_full = 32'(t2y_s1[31:16]) * 32'(ty_s1);

	logic [15:0] tx_s2, ty_s2, t3x_s2, t3y_s2;
	logic [19:0] polx_s2, poly_s2;

	always_ff @(posedge clk) begin
		tx_s2   <= tx_s1;
		ty_s2   <= ty_s1;
		t3x_s2  <= t3x_full[31:16];
		t3y_s2  <= t3y_full[31:16];
		polx_s2 <= pfn_pkg::FADE_C10 - ix_s1[35:16];
		poly_s2 <= pfn_pkg::FADE_C10 - iy_s1[35:16];
	end

	// Stage 3: gradient dot products and the finished fade values.
	logic signed [18:0] dx0, dy0, dx1, dy1;
	logic [35:0] fu_full, fv_full;
	assign dx0 = $signed({3'b000, tx_s2});
	assign dy0 = $signed({3'b000, ty_s2});
	assign dx1 = dx0 - pfn_pkg::ONE_FX;
	assign dy1 = dy0 - pfn_pkg::ONE_FX;
	assign fu_full = 36'(t3x_s2) * 36'(polx_s2);
	assign fv_full = 36'(t3y_s2) * 36'(poly_s2);

	logic signed [18:0] d00_s3, d01_s3, d10_s3, d11_s3;
	logic [16:0] u_s3, fv_s3;

	always_ff @(posedge clk) begin
		d00_s3 <= pfn_pkg::grad_dot(rdata[2][1:0], dx0, dy0);
		d01_s3 <= pfn_pkg::grad_dot(rdata[3][1:0], dx0, dy1);
		d10_s3 <= pfn_pkg::grad_dot(rdata[4][1:0], dx1, dy0);
		d11_s3 <= pfn_pkg::grad_dot(rdata[5][1:0], dx1, dy1);
		u_s3   <= fu_full[32:16];
		fv_s3  <= fv_full[32:16];
	end

	// Stage 4: products of the two lerps along y.
	logic signed [19:0] df0, df1;
	assign df0 = 20'(d01_s3) - 20'(d00_s3);
	assign df1 = 20'(d11_s3) - 20'(d10_s3);

	logic signed [37:0] p0_s4, p1_s4;
	logic signed [18:0] d00_s4, d10_s4;
	logic [16:0] u_s4;

	always_ff @(posedge clk) begin
		p0_s4  <= 38'($signed({1'b0, fv_s3}) * df0);
		p1_s4  <= 38'($signed({1'b0, fv_s3}) * df1);
		d00_s4 <= d00_s3;
		d10_s4 <= d10_s3;
		u_s4   <= u_s3;
	end

	// Stage 5: finish the y lerps with a floored shift.
	logic signed [37:0] q0, q1;
	assign q0 = p0_s4 >>> FB;
	assign q1 = p1_s4 >>> FB;

	logic signed [20:0] a_s5, b_s5;
	logic [16:0] u_s5;

	always_ff @(posedge clk) begin
		a_s5 <= 21'(d00_s4) + $signed(q0[20:0]);
		b_s5 <= 21'(d10_s4) + $signed(q1[20:0]);
		u_s5 <= u_s4;
	end

	// Stage 6: product of the lerp along x.
	logic signed [21:0] dab;
	assign dab = 22'(b_s5) - 22'(a_s5);

	logic signed [39:0] p2_s6;
	logic signed [20:0] a_s6;

	always_ff @(posedge clk) begin
		p2_s6 <= 40'($signed({1'b0, u_s5}) * dab);
		a_s6  <= a_s5;
	end

	// Stage 7: finish the x lerp and apply the octave amplitude.
	logic signed [39:0] q2;
	logic signed [21:0] nval;
	assign q2   = p2_s6 >>> FB;
	assign nval = 22'(a_s6) + $signed(q2[21:0]);

	logic signed [21:0] r_s7;

	always_ff @(posedge clk) begin
		r_s7 <= nval >>> sh_s6;
	end

	assign res.valid = v_s7;
	assign res.last  = l_s7;
	assign res.value = r_s7;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Perlin fBm noise unit
// Drives evaluate and table-write words with random gaps, predicts each noise
// result in fixed point and compares it with the unit's output word.
// ----------------------------------------------------------------------------
module tb_top;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = pfn_pkg::CMD_EVAL;
	logic signed [15:0] x_coord = '0;
	logic signed [15:0] y_coord = '0;
	logic [7:0]         perm_index = '0;
	logic [7:0]         perm_value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [17:0] noise_value;
	logic [7:0]         pixel_byte;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;

	typedef struct packed {
		logic signed [17:0] noise;
		logic [7:0]         pix;
	} noise_word_t;

	// Predictor state.
	logic [7:0]  pm_perm [pfn_pkg::TABLE_SIZE];
	logic [4:0]  pm_octaves;
	logic [23:0] pm_freq;

	noise_word_t noise_q[$];
	int          n_errors = 0;
	int          n_checked = 0;
	int          n_sent = 0;
	bit          hold_rx = 1'b0;
	int          gap_max = 3;

	perlin_fbm_noise_2d_unit u_dut (.*);

	always #5 clk = ~clk;

	function automatic longint fl_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fade_q(longint t);
		longint inner, poly, t2, t3;
		inner = (t * (15 * 65536 - 6 * t)) >>> 16;
		poly  = 10 * 65536 - inner;
		t2    = (t * t) >>> 16;
		t3    = (t2 * t) >>> 16;
		return (t3 * poly) >>> 16;
	endfunction

	function automatic longint lerp_q(longint t, longint a, longint b);
		return a + fl_shr(t * (b - a), 16);
	endfunction

	function automatic longint corner_dot(logic [7:0] h, longint dx, longint dy);
		longint sx, sy;
		sx = (h[1:0] == 2'd0 || h[1:0] == 2'd3) ? dx : -dx;
		sy = (h[1] == 1'b0) ? dy : -dy;
		return sx + sy;
	endfunction

	function automatic longint octave_q(logic signed [15:0] xc, logic signed [15:0] yc,
			int i);
		logic [63:0] f, px, py;
		logic [7:0]  cx, cy, pa, pb;
		longint      tx, ty, u, v, d00, d01, d10, d11;
		f  = 64'(pm_freq) << i;
		px = 64'(signed'(xc)) * f;
		py = 64'(signed'(yc)) * f;
		cx = px[31:24];
		cy = py[31:24];
		tx = longint'(px[23:8]);
		ty = longint'(py[23:8]);
		pa = pm_perm[cx];
		pb = pm_perm[8'(cx + 8'd1)];
		d00 = corner_dot(pm_perm[8'(pa + cy)], tx, ty);
		d01 = corner_dot(pm_perm[8'(pa + cy + 8'd1)], tx, ty - 65536);
		d10 = corner_dot(pm_perm[8'(pb + cy)], tx - 65536, ty);
		d11 = corner_dot(pm_perm[8'(pb + cy + 8'd1)], tx - 65536, ty - 65536);
		u = fade_q(tx);
		v = fade_q(ty);
		return lerp_q(u, lerp_q(v, d00, d01), lerp_q(v, d10, d11));
	endfunction

	function automatic noise_word_t predict_noise(logic signed [15:0] xc,
			logic signed [15:0] yc);
		noise_word_t w;
		longint      sum, s, b;
		int          n;
		sum = 0;
		n = (pm_octaves > pfn_pkg::MAX_OCTAVES) ? pfn_pkg::MAX_OCTAVES : pm_octaves;
		for (int i = 0; i < n; i++)
			sum += fl_shr(octave_q(xc, yc, i), i);
		if (sum > 131071) sum = 131071;
		if (sum < -131072) sum = -131072;
		s = sum + 65536;
		if (s <= 0) begin
			b = 0;
		end else begin
			b = (s * 255 + 65536) >>> 17;
			if (b > 255) b = 255;
		end
		w.noise = 18'(sum);
		w.pix   = 8'(b);
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// A gap is never empty: it always waits on the clock.
	task automatic random_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20 * gap_max) :
			$urandom_range(0, gap_max);
		repeat (g + 1) @(posedge clk);
	endtask

	// Send one word and wait for its acceptance; the predictor follows.
	task automatic send_word(logic c, logic signed [15:0] xc, logic signed [15:0] yc,
			logic [7:0] pi, logic [7:0] pv);
		in_valid   <= 1'b1;
		cmd        <= c;
		x_coord    <= xc;
		y_coord    <= yc;
		perm_index <= pi;
		perm_value <= pv;
		do @(posedge clk); while (in_stall);
		n_sent++;
		if (c == pfn_pkg::CMD_PERM) pm_perm[pi] = pv;
		else noise_q.push_back(predict_noise(xc, yc));
		if (gap_max > 0 && $urandom_range(0, 1)) begin
			in_valid <= 1'b0;
			random_gap();
		end
	endtask

	task automatic idle_tx();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (noise_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == pfn_pkg::REG_OCTAVES) pm_octaves = val[4:0];
		else if (idx == pfn_pkg::REG_BASE_FREQ) pm_freq = val;
		@(posedge clk);
	endtask

	task automatic eval_rand();
		send_word(pfn_pkg::CMD_EVAL, 16'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	// Directed: coordinate extremes, zero octaves, saturation of the count.
	task automatic test_directed();
		send_word(pfn_pkg::CMD_EVAL, 0, 0, 0, 0);
		send_word(pfn_pkg::CMD_EVAL, 16'sh7fff, 16'sh7fff, 8'hff, 8'hff);
		send_word(pfn_pkg::CMD_EVAL, -16'sd32768, -16'sd32768, 0, 0);
		send_word(pfn_pkg::CMD_EVAL, 16'sh7fff, -16'sd32768, 0, 0);
		send_word(pfn_pkg::CMD_EVAL, -1, 1, 0, 0);
		wait_drained();
		write_reg(pfn_pkg::REG_OCTAVES, 0);
		send_word(pfn_pkg::CMD_EVAL, 123, -456, 0, 0);
		wait_drained();
		write_reg(pfn_pkg::REG_OCTAVES, 31);
		write_reg(pfn_pkg::REG_BASE_FREQ, 24'hffffff);
		send_word(pfn_pkg::CMD_EVAL, 16'sh7fff, 16'sh1234, 0, 0);
		send_word(pfn_pkg::CMD_EVAL, -16'sd32768, 16'sh7fff, 0, 0);
		wait_drained();
		write_reg(pfn_pkg::REG_OCTAVES, 1);
		write_reg(pfn_pkg::REG_BASE_FREQ, 1);
		send_word(pfn_pkg::CMD_EVAL, -16'sd32768, 16'sh7fff, 0, 0);
		wait_drained();
		write_reg(pfn_pkg::REG_BASE_FREQ, 24'h800000);
		send_word(pfn_pkg::CMD_EVAL, 3, 1, 0, 0);
		wait_drained();
	endtask

	// Table writes, including a table that is no longer a permutation.
	task automatic test_table();
		write_reg(pfn_pkg::REG_OCTAVES, 4);
		write_reg(pfn_pkg::REG_BASE_FREQ, 24'h3a5c17);
		send_word(pfn_pkg::CMD_PERM, 0, 0, 8'h00, 8'hff);
		send_word(pfn_pkg::CMD_PERM, 0, 0, 8'hff, 8'h00);
		for (int k = 0; k < 60; k++) begin
			if ($urandom_range(0, 2) == 0)
				send_word(pfn_pkg::CMD_PERM, 16'($urandom), 16'($urandom),
					8'($urandom), 8'($urandom));
			else
				eval_rand();
		end
		wait_drained();
	endtask

	// Long receiver hold-off while the sender keeps offering words.
	task automatic test_backpressure();
		int saved;
		saved = gap_max;
		gap_max = 0;
		hold_rx = 1'b1;
		for (int k = 0; k < 20; k++) eval_rand();
		gap_max = saved;
		wait_drained();
	endtask

	// Random phases across several register settings.
	task automatic test_random();
		logic [4:0]  oct;
		logic [23:0] fr;
		for (int ph = 0; ph < 10; ph++) begin
			oct = (ph % 3 == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
			fr  = (ph % 4 == 0) ? 24'($urandom) : 24'($urandom_range(1, 24'h0fffff));
			write_reg(pfn_pkg::REG_OCTAVES, oct);
			write_reg(pfn_pkg::REG_BASE_FREQ, fr);
			gap_max = (ph % 3 == 1) ? 0 : 3;
			for (int k = 0; k < 135; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(pfn_pkg::CMD_PERM, 16'($urandom), 16'($urandom),
						8'($urandom), 8'($urandom));
				else
					eval_rand();
			end
			wait_drained();
		end
	endtask

	// Receiver stall: random gaps, or a long hold when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				random_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// Check each accepted output word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (noise_q.size() == 0) begin
				report_mismatch("unexpected word", noise_value, 0);
			end else begin
				noise_word_t w;
				w = noise_q.pop_front();
				n_checked++;
				if (noise_value !== w.noise)
					report_mismatch("noise_value", noise_value, w.noise);
				if (pixel_byte !== w.pix)
					report_mismatch("pixel_byte", pixel_byte, w.pix);
			end
		end
	end

	initial begin
		#20000000;
		$display("timeout with %0d words outstanding", noise_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		for (int k = 0; k < pfn_pkg::TABLE_SIZE; k++) pm_perm[k] = 8'(k);
		pm_octaves = pfn_pkg::OCTAVES_RESET;
		pm_freq    = pfn_pkg::BASE_FREQ_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table();
		test_backpressure();
		test_random();
		idle_tx();
		wait_drained();
		$display("sent %0d words, checked %0d noise results", n_sent, n_checked);
		$display("covered register extremes, table writes and long output stalls");
		if (n_errors == 0 && noise_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pfn_pkg.sv
rtl/pfn_ram.sv
rtl/pfn_perm.sv
rtl/pfn_octave.sv
rtl/perlin_fbm_noise_2d_unit.sv
tb/tb_top.sv
